/* hw/rtl/bdl_pkg.sv */
package bdl_pkg;

	localparam int unsigned CAPACITY_DEF = 256;

	localparam int unsigned ELEM_W = 32;
	localparam int unsigned POS_W  = 8;
	localparam int unsigned CNT_W  = 9;
	localparam int unsigned ACT_W  = 3;
	localparam int unsigned STAT_W = 2;

	// stream payload widths, padded to whole bytes
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_HEAD  = 3'd0,
		ACT_INS_TAIL  = 3'd1,
		ACT_REM_HEAD  = 3'd2,
		ACT_REM_TAIL  = 3'd3,
		ACT_READ_HEAD = 3'd4,
		ACT_READ_TAIL = 3'd5,
		ACT_READ_POS  = 3'd6
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

/* hw/rtl/bdl_store.sv */
module bdl_store #(
	parameter int unsigned DEPTH = bdl_pkg::CAPACITY_DEF,
	parameter int unsigned AW    = $clog2(bdl_pkg::CAPACITY_DEF)
) (
	input  logic                      clk,
	input  bdl_pkg::mem_ctl_t         ctl,
	input  logic [AW-1:0]             addr,
	input  logic [bdl_pkg::ELEM_W-1:0] wdata,
	output logic [bdl_pkg::ELEM_W-1:0] rdata
);
	import bdl_pkg::*;

	logic [ELEM_W-1:0] mem_q [DEPTH];
	logic [ELEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[addr] <= wdata;
		end
	end

	// hold the last word read until the next read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bounded_deque_list_top.sv */
// Each accepted input word yields one result word: the element memory read
// and stage-one registers come first, then the output register.
// Throughput: one word per cycle unless m_tready stalls the output; head slot
// and count update at the accept edge, so the next word may follow at once.
// Reset: arst_n clears head slot, count and all valid flags; element memory
// is not cleared and holds nothing meaningful until written.
module bounded_deque_list_top #(
	parameter int unsigned CAPACITY = bdl_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// elem_data[31:0], position[39:32]
	input  logic [bdl_pkg::IN_DATA_W-1:0]   s_tdata,
	// action[2:0]
	input  logic [bdl_pkg::ACT_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_data[31:0], count[40:32], zero padding above
	output logic [bdl_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [bdl_pkg::STAT_W-1:0]      m_tuser
);
	import bdl_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned OW = (CW > POS_W) ? CW : POS_W;
	localparam int unsigned SW = ((AW > OW) ? AW : OW) + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;

	action_t           act;
	logic [ELEM_W-1:0] elem;
	logic [POS_W-1:0]  pos;
	logic              accept;

	logic          full;
	logic          empty;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [OW-1:0] offset;
	logic [SW-1:0] slot_sum;
	logic [AW-1:0] slot;
	logic [AW-1:0] addr;
	logic          do_wr;
	logic          do_rd;
	logic          use_head_dec;
	logic [AW-1:0] nxt_head;
	logic [CW-1:0] nxt_cnt;
	status_t       st;
	mem_ctl_t      ctl;
	logic [ELEM_W-1:0] rdata;

	logic              valid_s1;
	logic              rd_s1;
	status_t           status_s1;
	logic [CW-1:0]     cnt_s1;
	logic              advance;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0]     m_tuser_q;

	assign act    = action_t'(s_tuser);
	assign elem   = s_tdata[ELEM_W-1:0];
	assign pos    = s_tdata[ELEM_W+POS_W-1:ELEM_W];
	assign accept = s_tvalid && s_tready;

	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	// head plus offset stays below twice the capacity: one subtract wraps it
	assign slot_sum = SW'(head_q) + SW'(offset);
	assign slot     = (slot_sum >= SW'(CAPACITY)) ? AW'(slot_sum - SW'(CAPACITY))
	                                              : AW'(slot_sum);
	assign addr     = use_head_dec ? head_dec : slot;

	always_comb begin
		nxt_head     = head_q;
		nxt_cnt      = cnt_q;
		st           = ST_OK;
		offset       = '0;
		do_wr        = 1'b0;
		do_rd        = 1'b0;
		use_head_dec = 1'b0;
		case (act)
			ACT_INS_HEAD: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					use_head_dec = 1'b1;
					do_wr        = 1'b1;
					nxt_head     = head_dec;
					nxt_cnt      = cnt_q + 1'b1;
				end
			end
			ACT_INS_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					offset  = OW'(cnt_q);
					do_wr   = 1'b1;
					nxt_cnt = cnt_q + 1'b1;
				end
			end
			ACT_REM_HEAD: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					nxt_head = head_inc;
					nxt_cnt  = cnt_q - 1'b1;
				end
			end
			ACT_REM_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					nxt_cnt = cnt_q - 1'b1;
				end
			end
			ACT_READ_HEAD: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					do_rd = 1'b1;
				end
			end
			ACT_READ_TAIL: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					offset = OW'(cnt_q - 1'b1);
					do_rd  = 1'b1;
				end
			end
			ACT_READ_POS: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (OW'(pos) >= OW'(cnt_q)) begin
					st = ST_RANGE;
				end else begin
					offset = OW'(pos);
					do_rd  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.wr_en = accept && do_wr;
	assign ctl.rd_en = accept && do_rd;

	bdl_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.ctl  (ctl),
		.addr (addr),
		.wdata(elem),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			head_q <= nxt_head;
			cnt_q  <= nxt_cnt;
		end
	end

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= do_rd;
			status_s1 <= st;
			cnt_s1    <= nxt_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// drop the memory word for anything but a successful read
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {{(OUT_DATA_W - ELEM_W - CNT_W){1'b0}}, CNT_W'(cnt_s1),
			              rd_s1 ? rdata : {ELEM_W{1'b0}}};
			m_tuser_q <= status_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
